[rtl/lbws_pkg.sv]
// Package for the lower-bound window selector: table sizes, field widths,
// payload structs, opcodes and sequencer states.
// Used by lower_bound_window_select and lbws_checker; depends on nothing.
package lbws_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_WIDTH   = 16;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int IDX_W       = $clog2(TABLE_DEPTH + 1);
  localparam int OUT_W       = 11;
  localparam int CFG_W       = 11;
  localparam int CALC_W      = ((IDX_W > CFG_W) ? IDX_W : CFG_W) + 1;

  localparam logic [CFG_W-1:0] SAMPLE_COUNT_RESET = CFG_W'(16);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEARCH,
    ST_CLAMP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]                  opcode;
    logic signed [KEY_WIDTH-1:0] key_value;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] window_start;
    logic [OUT_W-1:0] window_length;
    logic [OUT_W-1:0] bound_index;
    logic             status;
  } out_item_t;

endpackage

[rtl/lower_bound_window_select.sv]
// Top level of the lower-bound window selector: key table memory, search
// sequencer, window clamp and output register.
// Depends on lbws_pkg.
//
// Usage: software first clears the table (opcode 0), then appends keys in
// nondecreasing order (opcode 1), then sends query beats (opcode 2). Each
// input beat gives exactly one output beat. A query returns the lower-bound
// index L of its key, a window start clamped into [0, n-W] and the window
// length W, where W is sample_count rounded up to even. With fewer than W
// keys the whole table is returned. An append to a full table is dropped
// and answered with status 1.
// Channels: input and output use valid/stall, the config channel uses
// valid/ready and is always ready; it should be written only while idle.
// Sequencing: clear and append beats pass through ST_EXEC and ST_DONE; a
// query passes through ST_EXEC, ST_SEARCH, ST_CLAMP and ST_DONE, and its
// binary search makes up to 11 probes with 1024 keys, one after another;
// the single read port of the key memory, used once per probe, keeps them
// in sequence. A new beat is taken only once the last result has left
// ST_DONE. The result shows in the same cycle that in_stall_o drops for the
// next beat.
// Reset clears the key count, the sample count (to 16) and all handshake
// state; the key memory itself is not cleared. When the receiver stalls,
// the result waits in the output register and the block still accepts and
// works on the next beat, holding that result until the register frees.
module lower_bound_window_select
  import lbws_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  // Key table: one write port for appends, one registered read port for probes.
  logic signed [KEY_WIDTH-1:0] mem [TABLE_DEPTH];
  logic signed [KEY_WIDTH-1:0] rdata_q;
  logic                        mem_we;
  logic                        mem_re;
  logic [ADDR_W-1:0]           rd_addr;

  state_e           state_q, state_d;
  in_item_t         item_q, item_d;
  logic [IDX_W-1:0] count_q, count_d;
  logic [CFG_W-1:0] sc_q;
  logic [IDX_W-1:0] lo_q, lo_d;
  logic [IDX_W-1:0] hi_q, hi_d;
  logic [IDX_W-1:0] mid_q, mid_d;
  logic             pend_q, pend_d;
  out_item_t        res_q, res_d;
  out_item_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;

  // Search and clamp arithmetic.
  logic [IDX_W-1:0]  lo_n, hi_n;
  logic [IDX_W:0]    mid_sum;
  logic [CALC_W-1:0] n_c, w_c, b_c, half_c, top_c, st_c;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[ADDR_W-1:0]] <= item_q.key_value;
    end
    if (mem_re) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      sc_q        <= SAMPLE_COUNT_RESET;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        sc_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  // Window clamp on the final lower bound, which sits in lo_q.
  always_comb begin
    n_c    = CALC_W'(count_q);
    w_c    = CALC_W'(sc_q) + CALC_W'(sc_q[0]);
    b_c    = CALC_W'(lo_q);
    half_c = w_c >> 1;
    top_c  = n_c - w_c;
    st_c   = (b_c > half_c) ? (b_c - half_c) : '0;
    if (st_c > top_c) begin
      st_c = top_c;
    end
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    pend_d      = 1'b0;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    rd_addr     = mid_q[ADDR_W-1:0];
    lo_n        = lo_q;
    hi_n        = hi_q;
    mid_sum     = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_item_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_d   = '0;
        state_d = ST_DONE;
        case (opcode_e'(item_q.opcode))
          OP_CLEAR: begin
            count_d = '0;
          end
          OP_APPEND: begin
            if (count_q >= IDX_W'(TABLE_DEPTH)) begin
              res_d.status = 1'b1;
            end else begin
              mem_we  = 1'b1;
              count_d = count_q + IDX_W'(1);
            end
          end
          OP_QUERY: begin
            lo_d    = '0;
            hi_d    = count_q;
            state_d = ST_SEARCH;
          end
          default: begin
            // Unused opcode: table left unchanged, all-zero result.
          end
        endcase
      end
      ST_SEARCH: begin
        // Fold in the probe read last cycle, then issue the next one.
        if (pend_q) begin
          if (rdata_q < item_q.key_value) begin
            lo_n = mid_q + IDX_W'(1);
          end else begin
            hi_n = mid_q;
          end
        end
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n < hi_n) begin
          mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
          mid_d   = mid_sum[IDX_W:1];
          rd_addr = mid_sum[ADDR_W:1];
          mem_re  = 1'b1;
          pend_d  = 1'b1;
        end else begin
          state_d = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        res_d.bound_index = OUT_W'(lo_q);
        res_d.status      = 1'b0;
        if (n_c < w_c) begin
          res_d.window_start  = '0;
          res_d.window_length = OUT_W'(n_c);
        end else begin
          res_d.window_start  = OUT_W'(st_c);
          res_d.window_length = OUT_W'(w_c);
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/lbws_checker.sv]
// Port-level checker for lower_bound_window_select, with its bind statement.
// Depends on lbws_pkg.
module lbws_checker
  import lbws_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input out_item_t out_item_o,
  input logic      out_valid_o,
  input logic      out_stall_i
);

  // One beat at a time: an accepted beat blocks the input on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted again right after a beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result beat changed");

  a_drop_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status) |->
      (out_item_o.window_start == '0 && out_item_o.window_length == '0 &&
       out_item_o.bound_index == '0))
    else $error("dropped append carries window fields");

  a_window_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((CALC_W'(out_item_o.window_start) + CALC_W'(out_item_o.window_length)
        <= CALC_W'(TABLE_DEPTH)) &&
       (CALC_W'(out_item_o.bound_index) <= CALC_W'(TABLE_DEPTH))))
    else $error("window runs past the table");

endmodule

bind lower_bound_window_select lbws_checker u_lbws_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_item_o  (out_item_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);
